FILE: sv/tgr_pkg.sv
// ============================================================================
// tgr_pkg
// Shared types and constants for the text glyph renderer: font store
// geometry, register indexes, item actions and controller/datapath links.
// ============================================================================
package tgr_pkg;

  // Font store geometry.
  localparam int MAX_GLYPH_ROWS = 32;
  localparam int CHAR_COUNT     = 256;
  localparam int GLYPH_WIDTH    = 8;
  localparam int STORE_DEPTH    = CHAR_COUNT * MAX_GLYPH_ROWS;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int ROW_W          = $clog2(MAX_GLYPH_ROWS);
  localparam int HGT_W          = $clog2(MAX_GLYPH_ROWS + 1);

  // Fixed field widths.
  localparam int CODE_W   = 8;
  localparam int GROW_W   = 5;
  localparam int BITS_W   = 8;
  localparam int PITCH_W  = 14;
  localparam int SWID_W   = 14;
  localparam int GHGT_W   = 6;
  localparam int COLOR_W  = 32;
  localparam int COL_W    = 13;
  localparam int LINE_W   = 16;
  localparam int ADDR_W   = 48;
  localparam int PROD_W   = LINE_W + PITCH_W;
  localparam int PIX_W    = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_PITCH   = 3'd0,
    REG_SCREEN_WIDTH = 3'd1,
    REG_GLYPH_HEIGHT = 3'd2,
    REG_TEXT_COLOR   = 3'd3,
    REG_START_COLUMN = 3'd4,
    REG_START_ROW    = 3'd5,
    REG_FRAME_BASE   = 3'd6
  } cfg_reg_e;

  // Input item actions.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;         // write one glyph row from the request
    logic             latch;        // capture the character code of a draw
    logic             issue;        // start one row through the pipeline
    logic [ROW_W-1:0] row;          // glyph row being issued
    logic             last;         // issued row is the final one
    logic             cursor_step;  // advance the text cursor
  } tgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             advance;      // row pipeline can move this cycle
    logic [HGT_W-1:0] height;       // glyph height, saturated
  } tgr_status_t;

  // Font store index of one glyph row.
  function automatic logic [STORE_AW-1:0] store_index(input logic [CODE_W-1:0] code,
                                                      input logic [GROW_W-1:0] row);
    return STORE_AW'(32'(code) * MAX_GLYPH_ROWS + 32'(row));
  endfunction

endpackage

FILE: sv/tgr_ctrl.sv
// ============================================================================
// tgr_ctrl
// Controller of the text glyph renderer. Accepts requests, sequences the
// glyph rows of a draw into the datapath and steps the cursor at the end.
// ============================================================================
module tgr_ctrl
  import tgr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  tgr_status_t st_i,
  output tgr_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } tgr_state_e;

  tgr_state_e       state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_row;

  // The current row is the last one when its count reaches the height.
  assign last_row = ((HGT_W'(row_q) + HGT_W'(1)) == st_i.height);

  // Requests are taken only between draws.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cmd_o   = '0;
    cmd_o.row  = row_q;
    cmd_o.last = last_row;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            if (st_i.height == '0) begin
              cmd_o.cursor_step = 1'b1;
            end else begin
              state_d = ST_ISSUE;
              row_d   = '0;
            end
          end
        end
      end
      ST_ISSUE: begin
        if (st_i.advance) begin
          cmd_o.issue = 1'b1;
          if (last_row) begin
            cmd_o.cursor_step = 1'b1;
            state_d = ST_IDLE;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  // A row is issued only when the pipeline can take it.
  a_issue_needs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> st_i.advance)
    else $error("row issued while the pipeline is held");

  // The cursor steps only as a draw finishes, after which the controller is idle.
  a_step_ends_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cursor_step |=> (state_q == ST_IDLE))
    else $error("cursor stepped in the middle of a draw");

  // A glyph load never overlaps row issue or a draw start.
  a_load_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!cmd_o.issue && !cmd_o.latch))
    else $error("glyph load collides with a draw");

endmodule

FILE: sv/tgr_datapath.sv
// ============================================================================
// tgr_datapath
// Datapath of the text glyph renderer: configuration registers, font store,
// text cursor and the row pipeline that forms masked row writes.
// ============================================================================
module tgr_datapath
  import tgr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Request payload.
  input  logic [CODE_W-1:0]     char_code_i,
  input  logic [GROW_W-1:0]     glyph_row_i,
  input  logic [BITS_W-1:0]     row_bits_i,
  // Controller link.
  input  tgr_cmd_t              cmd_i,
  output tgr_status_t           st_o,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     write_address_o,
  output logic [BITS_W-1:0]     pixel_mask_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  last_row_o
);

  // Configuration and cursor.
  logic [PITCH_W-1:0] line_pitch_q;
  logic [SWID_W-1:0]  screen_width_q;
  logic [GHGT_W-1:0]  glyph_height_q;
  logic [COLOR_W-1:0] text_color_q;
  logic [ADDR_W-1:0]  frame_base_q;
  logic [COL_W-1:0]   cursor_col_q;
  logic [LINE_W-1:0]  cursor_line_q;
  logic [HGT_W-1:0]   height;

  // Latched draw code.
  logic [CODE_W-1:0]  code_q;
  logic               code_ok_q;

  // Font store.
  logic [BITS_W-1:0]  store_mem [STORE_DEPTH];
  logic [BITS_W-1:0]  rdata_q;
  logic               store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [STORE_AW-1:0] store_raddr;

  // Row pipeline stage and output register.
  logic               vld_b_q;
  logic [PROD_W-1:0]  prod_b_q;
  logic [COL_W-1:0]   col_b_q;
  logic               last_b_q;
  logic               ok_b_q;
  logic [LINE_W-1:0]  row_y;
  logic [PIX_W-1:0]   pix;
  logic               advance;
  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [BITS_W-1:0]  out_mask_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  // Cursor step.
  logic [COL_W:0]     col_next;
  logic [COL_W+1:0]   col_reach;

  // Glyph height saturates at the store's row count.
  assign height = (32'(glyph_height_q) > MAX_GLYPH_ROWS) ? HGT_W'(MAX_GLYPH_ROWS)
                                                         : HGT_W'(glyph_height_q);

  // The pipeline moves when the output slot is empty or being taken.
  assign advance = !out_valid_q || !out_stall_i;
  assign st_o.advance = advance;
  assign st_o.height  = height;

  // Next cursor column and the right edge of the following glyph.
  assign col_next  = (COL_W+1)'(cursor_col_q) + (COL_W+1)'(GLYPH_WIDTH);
  assign col_reach = (COL_W+2)'(col_next) + (COL_W+2)'(GLYPH_WIDTH);

  // Configuration registers, cursor and latched code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pitch_q   <= PITCH_W'(1024);
      screen_width_q <= SWID_W'(1024);
      glyph_height_q <= GHGT_W'(16);
      text_color_q   <= COLOR_W'(32'hFF_FFFF);
      frame_base_q   <= '0;
      cursor_col_q   <= '0;
      cursor_line_q  <= '0;
      code_q         <= '0;
      code_ok_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_LINE_PITCH:   line_pitch_q   <= cfg_data_i[PITCH_W-1:0];
          REG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[SWID_W-1:0];
          REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i[GHGT_W-1:0];
          REG_TEXT_COLOR:   text_color_q   <= cfg_data_i[COLOR_W-1:0];
          REG_START_COLUMN: cursor_col_q   <= cfg_data_i[COL_W-1:0];
          REG_START_ROW:    cursor_line_q  <= cfg_data_i[LINE_W-1:0];
          REG_FRAME_BASE:   frame_base_q   <= cfg_data_i[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.latch) begin
        code_q    <= char_code_i;
        code_ok_q <= (32'(char_code_i) < CHAR_COUNT);
      end
      // Move right one glyph, or to the start of the next text line.
      if (cmd_i.cursor_step) begin
        if (col_reach > (COL_W+2)'(screen_width_q)) begin
          cursor_col_q  <= '0;
          cursor_line_q <= cursor_line_q + LINE_W'(height);
        end else begin
          cursor_col_q  <= col_next[COL_W-1:0];
        end
      end
    end
  end

  // Font store ports: one write for a load, one registered read per row.
  assign store_we    = cmd_i.load && (32'(char_code_i) < CHAR_COUNT)
                                  && (32'(glyph_row_i) < MAX_GLYPH_ROWS);
  assign store_waddr = store_index(char_code_i, glyph_row_i);
  assign store_raddr = store_index(code_q, GROW_W'(cmd_i.row));

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= row_bits_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= store_mem[store_raddr];
    end
  end

  // Scanline of the issued row, wrapping at 16 bits.
  assign row_y = cursor_line_q + LINE_W'(cmd_i.row);

  // Row stage: scanline offset product alongside the store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (advance) begin
      vld_b_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_b_q <= PROD_W'(row_y) * PROD_W'(line_pitch_q);
      col_b_q  <= cursor_col_q;
      last_b_q <= cmd_i.last;
      ok_b_q   <= code_ok_q;
    end
  end

  // Pixel index of the row's leftmost pixel.
  assign pix = PIX_W'(col_b_q) + PIX_W'(prod_b_q);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && vld_b_q) begin
      out_addr_q  <= frame_base_q + ADDR_W'({pix, 2'b00});
      out_mask_q  <= ok_b_q ? rdata_q : '0;
      out_color_q <= text_color_q;
      out_last_q  <= last_b_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = out_addr_q;
  assign pixel_mask_o    = out_mask_q;
  assign pixel_color_o   = out_color_q;
  assign last_row_o      = out_last_q;

  // A held row keeps its store data until it moves on.
  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && !advance) |=> $stable(rdata_q))
    else $error("store read data changed under a held row");

  // A held row is not lost.
  a_row_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && !advance) |=> vld_b_q)
    else $error("held row dropped from the pipeline");

  // Every issued row enters the row stage.
  a_issue_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> vld_b_q)
    else $error("issued row did not enter the row stage");

endmodule

FILE: sv/text_glyph_renderer_unit.sv
// ============================================================================
// text_glyph_renderer_unit
// Bitmap font text renderer with an 8-pixel-wide font store and text cursor.
// ============================================================================
// Usage:
// The request channel (in_valid_i / in_stall_o) carries loads and draws. A
// load writes one glyph row into the font store. A draw produces one masked
// row write per glyph row on the result channel (out_valid_o / out_stall_i),
// the final one flagged by last_row_o, then moves the cursor one glyph right
// or to the next text line.
// A draw occupies the request side until it has issued all H glyph rows, H
// being the glyph height saturated at 32; the row pipeline sends one row per
// cycle while the receiver does not stall, limited by the single read port of
// the font store. Each row passes the row stage and the output register.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready; it
// must be written only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and puts the cursor at column 0,
// line 0; the font store keeps no reset value and must be loaded first.
// When the receiver stalls, the result holds and row issue pauses; requests
// stay blocked until the current draw has issued all its rows.
// ============================================================================
module text_glyph_renderer_unit
  import tgr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [CODE_W-1:0]     char_code_i,
  input  logic [GROW_W-1:0]     glyph_row_i,
  input  logic [BITS_W-1:0]     row_bits_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     write_address_o,
  output logic [BITS_W-1:0]     pixel_mask_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  last_row_o
);

  tgr_cmd_t    cmd;
  tgr_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  // Request sequencing.
  tgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .st_i       (status),
    .cmd_o      (cmd)
  );

  // Storage and row address generation.
  tgr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .char_code_i     (char_code_i),
    .glyph_row_i     (glyph_row_i),
    .row_bits_i      (row_bits_i),
    .cmd_i           (cmd),
    .st_o            (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .pixel_mask_o    (pixel_mask_o),
    .pixel_color_o   (pixel_color_o),
    .last_row_o      (last_row_o)
  );

endmodule
